@@ rtl/core/sma_pkg.sv @@
// Shared constants and codes for the stack machine ALU core.
// No dependencies; imported by the core and the checker.
package sma_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W      = $clog2(DATA_W);

  localparam int OPERATION_W = 3;
  localparam int OPERAND_W   = 32;
  localparam int TOP_W       = 32;
  localparam int DEPTH_W     = 9;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = ((OPERAND_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((TOP_W + DEPTH_W + 7) / 8) * 8;

  typedef enum logic [OPERATION_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_ADD     = 3'd2,
    OP_SUB     = 3'd3,
    OP_MUL     = 3'd4,
    OP_DIV     = 3'd5,
    OP_HALT    = 3'd6,
    OP_UNKNOWN = 3'd7
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_HALTED     = 3'd1,
    ST_UNKNOWN_OP = 3'd2,
    ST_UNDERFLOW  = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_DIV_ZERO   = 3'd5,
    ST_STOPPED    = 3'd6
  } status_t;

endpackage

@@ rtl/core/stack_machine_alu_core.sv @@
// Stack machine ALU core: one instruction per input word, one result word per input word.
// Accept to result: push, pop to empty, halt, stopped words and errors found at accept go
// IDLE -> DONE; other pops, add, sub and divide by zero IDLE -> READ -> DONE (one stack
// RAM read); mul, div also ITER, FIN, one bit per cycle in the shared add/subtract unit.
// One word in flight: a new word waits until the last result is loaded for output.
// Reset (rst_n, synchronous, active low) empties the stack and clears stop. Uses sma_pkg, sma_ram.
module stack_machine_alu_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [31:0] operand
  input  logic [sma_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: [2:0] operation
  input  logic [sma_pkg::OPERATION_W-1:0] in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: [31:0] top_value, [40:32] depth, [47:41] zero
  output logic [sma_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [2:0] status
  output logic [sma_pkg::STATUS_W-1:0]    out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready
);
  import sma_pkg::*;

  // IDLE takes a word; READ has the entry below the top from RAM; ITER runs
  // the bit-serial mul/div; FIN writes the product/quotient back; DONE hands
  // the result to the output register.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ITER,
    S_FIN,
    S_DONE
  } state_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  state_t              state_r, state_nxt;
  opcode_t             op_r, op_nxt;
  status_t             stat_r, stat_nxt;
  logic [CNT_W-1:0]    depth_r, depth_nxt;
  logic [DATA_W-1:0]   tos_r, tos_nxt;     // cached top of stack
  logic                stopped_r, stopped_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;     // product / remainder
  logic [DATA_W-1:0]   opa_r, opa_nxt;     // multiplicand / divisor magnitude
  logic [DATA_W-1:0]   opb_r, opb_nxt;     // multiplier / dividend -> quotient
  logic                neg_r, neg_nxt;     // quotient sign
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TOP_W-1:0]    out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;
  status_t             out_stat_r, out_stat_nxt;

  logic                accept;
  opcode_t             in_op;
  logic [DATA_W-1:0]   imm;

  // stack RAM ports
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_wa, ram_ra;
  logic [DATA_W-1:0]   ram_wd, ram_rd;

  // shared add/subtract unit, one bit wider than the data for the borrow
  logic [DATA_W:0]     unit_x, unit_y, unit_sum;
  logic                unit_sub;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W-1:0]   mag_a, mag_b, result;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_op     = opcode_t'(in_tuser);
  // operand is sign-extended, then fit to the datapath width
  assign imm       = DATA_W'(signed'(in_tdata[OPERAND_W-1:0]));

  assign rem_sh    = {acc_r, opb_r[DATA_W-1]};
  assign mag_a     = ram_rd[DATA_W-1] ? (~ram_rd + DATA_W'(1)) : ram_rd;
  assign mag_b     = tos_r[DATA_W-1]  ? (~tos_r + DATA_W'(1))  : tos_r;
  assign result    = (op_r == OP_MUL) ? acc_r : (neg_r ? (~opb_r + DATA_W'(1)) : opb_r);

  always_comb begin
    unit_x   = {1'b0, ram_rd};
    unit_y   = {1'b0, tos_r};
    unit_sub = (op_r == OP_SUB);
    if (state_r == S_ITER) begin
      unit_y = {1'b0, opa_r};
      if (op_r == OP_MUL) begin
        unit_x   = {1'b0, acc_r};
        unit_sub = 1'b0;
      end else begin
        unit_x   = rem_sh;
        unit_sub = 1'b1;
      end
    end
  end

  assign unit_sum = unit_x + (unit_y ^ {(DATA_W + 1){unit_sub}}) + (DATA_W + 1)'(unit_sub);

  sma_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    stat_nxt      = stat_r;
    depth_nxt     = depth_r;
    tos_nxt       = tos_r;
    stopped_nxt   = stopped_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_top_nxt   = out_top_r;
    out_depth_nxt = out_depth_r;
    out_stat_nxt  = out_stat_r;

    ram_we = 1'b0;
    ram_wa = ADDR_W'(depth_r - CNT_W'(2)); // second entry from the top
    ram_wd = result;
    ram_re = 1'b0;
    ram_ra = ADDR_W'(depth_r - CNT_W'(2));

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          stat_nxt  = ST_OK;
          state_nxt = S_DONE;
          if (stopped_r) begin
            stat_nxt = ST_STOPPED;
          end else begin
            unique case (in_op) inside
              OP_PUSH: begin
                if (depth_r == CNT_W'(STACK_DEPTH)) begin
                  stat_nxt = ST_OVERFLOW;
                end else begin
                  ram_we    = 1'b1;
                  ram_wa    = ADDR_W'(depth_r);
                  ram_wd    = imm;
                  tos_nxt   = imm;
                  depth_nxt = depth_r + CNT_W'(1);
                end
              end
              OP_POP: begin
                if (depth_r == '0) begin
                  stat_nxt = ST_UNDERFLOW;
                end else if (depth_r == CNT_W'(1)) begin
                  depth_nxt = '0;
                end else begin
                  // new top comes from RAM
                  ram_re    = 1'b1;
                  state_nxt = S_READ;
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (depth_r < CNT_W'(2)) begin
                  stat_nxt = ST_UNDERFLOW;
                end else begin
                  ram_re    = 1'b1;
                  state_nxt = S_READ;
                end
              end
              OP_HALT: stat_nxt = ST_HALTED;
              default: stat_nxt = ST_UNKNOWN_OP;
            endcase
          end
        end
      end

      S_READ: begin
        // ram_rd is the lower (left) operand, tos_r the right one
        state_nxt = S_DONE;
        case (op_r) inside
          OP_POP: begin
            tos_nxt   = ram_rd;
            depth_nxt = depth_r - CNT_W'(1);
          end
          OP_ADD, OP_SUB: begin
            ram_we    = 1'b1;
            ram_wd    = unit_sum[DATA_W-1:0];
            tos_nxt   = unit_sum[DATA_W-1:0];
            depth_nxt = depth_r - CNT_W'(1);
          end
          OP_MUL: begin
            acc_nxt   = '0;
            opa_nxt   = ram_rd;
            opb_nxt   = tos_r;
            step_nxt  = '0;
            state_nxt = S_ITER;
          end
          OP_DIV: begin
            if (tos_r == '0) begin
              stat_nxt = ST_DIV_ZERO;
            end else begin
              // unsigned restoring divide on magnitudes, sign fixed at the end
              acc_nxt   = '0;
              opa_nxt   = mag_b;
              opb_nxt   = mag_a;
              neg_nxt   = ram_rd[DATA_W-1] ^ tos_r[DATA_W-1];
              step_nxt  = '0;
              state_nxt = S_ITER;
            end
          end
          default: ;
        endcase
      end

      S_ITER: begin
        if (op_r == OP_MUL) begin
          // shift-add, low DATA_W bits of the product only
          if (opb_r[0]) begin
            acc_nxt = unit_sum[DATA_W-1:0];
          end
          opa_nxt = {opa_r[DATA_W-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[DATA_W-1:1]};
        end else begin
          // keep the difference when no borrow, shift in the quotient bit
          acc_nxt = unit_sum[DATA_W] ? rem_sh[DATA_W-1:0] : unit_sum[DATA_W-1:0];
          opb_nxt = {opb_r[DATA_W-2:0], ~unit_sum[DATA_W]};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        ram_we    = 1'b1;
        tos_nxt   = result;
        depth_nxt = depth_r - CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // load the output register once the previous result has gone
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = (depth_r == '0) ? '0 : TOP_W'(signed'(tos_r));
          out_depth_nxt = DEPTH_W'(depth_r);
          out_stat_nxt  = stat_r;
          if (stat_r != ST_OK) begin
            stopped_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    stat_r      <= stat_nxt;
    tos_r       <= tos_nxt;
    acc_r       <= acc_nxt;
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    neg_r       <= neg_nxt;
    step_r      <= step_nxt;
    out_top_r   <= out_top_nxt;
    out_depth_r <= out_depth_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_depth_r, out_top_r});
  assign out_tuser  = out_stat_r;

endmodule

@@ rtl/core/sma_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/sma_checker.sv @@
// Port-level checker for stack_machine_alu_core, attached by bind.
// Depends on sma_pkg.
module sma_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic [sma_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [sma_pkg::OPERATION_W-1:0] in_tuser,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [sma_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [sma_pkg::STATUS_W-1:0]    out_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready
);
  import sma_pkg::*;

  logic                stopped_seen_r;
  logic [DEPTH_W-1:0]  out_depth;
  logic [TOP_W-1:0]    out_top;

  assign out_depth = out_tdata[TOP_W +: DEPTH_W];
  assign out_top   = out_tdata[TOP_W-1:0];

  // a delivered non-ok status stops the machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && (out_tuser != ST_OK)) begin
      stopped_seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  a_stays_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && stopped_seen_r) |-> (out_tuser == ST_STOPPED))
    else $error("stopped machine reported other than already-stopped");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_depth <= DEPTH_W'(STACK_DEPTH)))
    else $error("depth beyond stack size");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_depth == '0)) |-> (out_top == '0))
    else $error("empty stack with nonzero top");

endmodule

bind stack_machine_alu_core sma_checker u_sma_checker (.*);
